[rtl/core/wca_pkg.sv]
package wca_pkg;

  localparam int unsigned ChanCount = 4;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned ProdW     = 24;
  localparam int unsigned SumW      = 32;
  localparam int unsigned TotalW    = 24;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned CfgIdxW   = 2;

  // request codes
  localparam logic [1:0] ReqSet   = 2'd0;
  localparam logic [1:0] ReqMix   = 2'd1;
  localparam logic [1:0] ReqFinal = 2'd2;

  // one table row: four channel sums and the total weight
  typedef struct packed {
    logic [ChanCount-1:0][SumW-1:0] sum;
    logic [TotalW-1:0]              total;
  } wca_row_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;       // latch the request word
    logic       rd;         // read the addressed row
    logic       upd;        // write back set / mix-in row
    logic       clr;        // clear one row of the reset sweep
    logic       div_load;   // load divider with channel chan
    logic       div_step;   // one restoring step
    logic       div_store;  // keep quotient of channel chan
    logic [1:0] chan;
    logic       res_fire;   // load output word and strobe
  } wca_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_ok;      // legal code and index in range
    logic is_final;
    logic total_zero;
    logic clr_last;
  } wca_sts_t;

endpackage

[rtl/core/wca_ctrl.sv]
module wca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  wca_pkg::wca_sts_t sts_i,
  output wca_pkg::wca_cmd_t cmd_o
);
  import wca_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DLOAD,
    S_DSTEP,
    S_DSTORE,
    S_FIRE
  } state_e;

  state_e     state_q;
  logic [1:0] chan_q;
  logic [2:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      chan_q  <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) state_q <= S_READ;
        end
        S_READ: begin
          state_q <= sts_i.req_ok ? S_EXEC : S_IDLE;
        end
        S_EXEC: begin
          chan_q <= '0;
          if (!sts_i.is_final) begin
            state_q <= S_IDLE;
          end else if (sts_i.total_zero) begin
            state_q <= S_FIRE;
          end else begin
            state_q <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          step_q  <= '0;
          state_q <= S_DSTEP;
        end
        S_DSTEP: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) state_q <= S_DSTORE;
        end
        S_DSTORE: begin
          chan_q <= chan_q + 2'd1;
          state_q <= (chan_q == 2'd3) ? S_FIRE : S_DLOAD;
        end
        S_FIRE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.chan      = chan_q;
    cmd_o.take      = (state_q == S_IDLE) && start_i;
    cmd_o.clr       = (state_q == S_CLEAR);
    cmd_o.rd        = (state_q == S_READ);
    cmd_o.upd       = (state_q == S_EXEC) && !sts_i.is_final;
    cmd_o.div_load  = (state_q == S_DLOAD);
    cmd_o.div_step  = (state_q == S_DSTEP);
    cmd_o.div_store = (state_q == S_DSTORE);
    cmd_o.res_fire  = (state_q == S_FIRE);
  end

endmodule

[rtl/core/wca_dp.sv]
module wca_dp #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wca_pkg::wca_cmd_t                     cmd_i,
  output wca_pkg::wca_sts_t                     sts_o,
  input  logic                                  cfg_valid_i,
  input  logic [wca_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [wca_pkg::ColorW-1:0]            cfg_data_i,
  input  logic [1:0]                            req_type_i,
  input  logic [wca_pkg::IndexW-1:0]            entry_index_i,
  input  logic [wca_pkg::ColorW-1:0]            in_red_i,
  input  logic [wca_pkg::ColorW-1:0]            in_green_i,
  input  logic [wca_pkg::ColorW-1:0]            in_blue_i,
  input  logic [wca_pkg::ColorW-1:0]            in_alpha_i,
  input  logic [wca_pkg::WeightW-1:0]           contrib_weight_i,
  output logic                                  out_valid_o,
  output logic [wca_pkg::IndexW-1:0]            out_index_o,
  output logic [wca_pkg::ColorW-1:0]            out_red_o,
  output logic [wca_pkg::ColorW-1:0]            out_green_o,
  output logic [wca_pkg::ColorW-1:0]            out_blue_o,
  output logic [wca_pkg::ColorW-1:0]            out_alpha_o,
  output logic                                  used_default_o
);
  import wca_pkg::*;

  localparam int AddrW = $clog2(ENTRY_COUNT);
  localparam int ExtW  = (AddrW > IndexW) ? AddrW : IndexW;

  // request word
  logic [1:0]                          req_q;
  logic [IndexW-1:0]                   idx_q;
  logic [ChanCount-1:0][ColorW-1:0]    color_q;
  logic [WeightW-1:0]                  w_q;
  logic [ChanCount-1:0][ProdW-1:0]     prod_q;

  logic [ExtW-1:0]  idx_ext;
  logic [AddrW-1:0] addr;

  // table
  wca_row_t         mem_q [ENTRY_COUNT];
  wca_row_t         rdata_q;
  wca_row_t         upd_row;
  wca_row_t         wr_data;
  logic [AddrW-1:0] wr_addr;
  logic             wr_en;
  logic [AddrW-1:0] clr_q;

  // divider
  logic [TotalW-1:0]   rem_q;
  logic [ColorW-1:0]   src_q;
  logic [ColorW-1:0]   quo_q;
  logic                sat_q;
  logic [SumW-1:0]     sel_sum;
  logic [TotalW:0]     rem_sh;
  logic [TotalW:0]     tot_ext;
  logic [TotalW:0]     rem_sub;
  logic                rem_ge;

  logic [ChanCount-1:0][ColorW-1:0] res_q;
  logic [ChanCount-1:0][ColorW-1:0] def_q;

  logic                             out_valid_q;
  logic [IndexW-1:0]                out_index_q;
  logic [ChanCount-1:0][ColorW-1:0] out_color_q;
  logic                             used_default_q;

  logic [SumW:0]   mix_sum [ChanCount];
  logic [TotalW:0] mix_tot;

  assign idx_ext = ExtW'(idx_q);
  assign addr    = idx_ext[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q      <= req_type_i;
      idx_q      <= entry_index_i;
      color_q[0] <= in_red_i;
      color_q[1] <= in_green_i;
      color_q[2] <= in_blue_i;
      color_q[3] <= in_alpha_i;
      w_q        <= contrib_weight_i;
    end
    if (cmd_i.rd) begin
      for (int c = 0; c < ChanCount; c++) begin
        prod_q[c] <= ProdW'(color_q[c]) * ProdW'(w_q);
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.req_ok     = ((req_q == ReqSet) || (req_q == ReqMix) || (req_q == ReqFinal))
                       && (32'(idx_q) < 32'(ENTRY_COUNT));
    sts_o.is_final   = (req_q == ReqFinal);
    sts_o.total_zero = (rdata_q.total == '0);
    sts_o.clr_last   = (clr_q == AddrW'(ENTRY_COUNT - 1));
  end

  // set / mix-in row, saturating
  always_comb begin
    upd_row = rdata_q;
    for (int c = 0; c < ChanCount; c++) begin
      mix_sum[c] = {1'b0, rdata_q.sum[c]} + (SumW + 1)'(prod_q[c]);
      if (req_q == ReqMix) begin
        upd_row.sum[c] = mix_sum[c][SumW] ? '1 : mix_sum[c][SumW-1:0];
      end else begin
        upd_row.sum[c] = SumW'(prod_q[c]);
      end
    end
    mix_tot = {1'b0, rdata_q.total} + (TotalW + 1)'(w_q);
    if (req_q == ReqMix) begin
      upd_row.total = mix_tot[TotalW] ? '1 : mix_tot[TotalW-1:0];
    end else begin
      upd_row.total = TotalW'(w_q);
    end
  end

  assign wr_en   = cmd_i.clr || cmd_i.upd;
  assign wr_addr = cmd_i.clr ? clr_q : addr;
  assign wr_data = cmd_i.clr ? '0 : upd_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // restoring divide: the top 24 bits decide clamping, then 8 quotient bits
  assign sel_sum = rdata_q.sum[cmd_i.chan];
  assign rem_sh  = {rem_q, src_q[ColorW-1]};
  assign tot_ext = {1'b0, rdata_q.total};
  assign rem_ge  = (rem_sh >= tot_ext);
  assign rem_sub = rem_sh - tot_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      sat_q <= (sel_sum[SumW-1:ColorW] >= rdata_q.total);
      rem_q <= sel_sum[SumW-1:ColorW];
      src_q <= sel_sum[ColorW-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[TotalW-1:0] : rem_sh[TotalW-1:0];
      src_q <= {src_q[ColorW-2:0], 1'b0};
      quo_q <= {quo_q[ColorW-2:0], rem_ge};
    end
    if (cmd_i.div_store) begin
      res_q[cmd_i.chan] <= sat_q ? '1 : quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q <= '0;
    end else if (cfg_valid_i) begin
      def_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_fire) begin
      out_index_q    <= idx_q;
      used_default_q <= sts_o.total_zero;
      out_color_q    <= sts_o.total_zero ? def_q : res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign out_red_o      = out_color_q[0];
  assign out_green_o    = out_color_q[1];
  assign out_blue_o     = out_color_q[2];
  assign out_alpha_o    = out_color_q[3];
  assign used_default_o = used_default_q;

endmodule

[rtl/core/weighted_color_average_table_core.sv]
// Table of weighted color accumulators, one row per entry: four channel sums
// and a total weight.
// Request channel: drive the request word and raise start_i; the word is taken
// at a rising edge with start_i high and busy_o low. Set and mix-in go through
// a row read, then a read-modify-write. Finalize does a row read, then one
// shared restoring divider runs load, 8 quotient steps and store for each of
// the four channels in turn. A finalize on an entry with zero weight skips the
// divider and returns the default color.
// Results: out_valid_o is high for one cycle, the same cycle busy_o is low again,
// with the result word on the out_* ports; the receiver cannot hold it off.
// Illegal codes and out-of-range indexes are dropped after the row read.
// Configuration: cfg_ready_o is always high; a write of a default channel is
// taken at any edge with cfg_valid_i high.
// Reset: the table is swept to zero, one row per cycle, through all
// ENTRY_COUNT rows; busy_o stays high during the sweep. Defaults reset to zero.
module weighted_color_average_table_core #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    req_type_i,
  input  logic [wca_pkg::IndexW-1:0]    entry_index_i,
  input  logic [wca_pkg::ColorW-1:0]    in_red_i,
  input  logic [wca_pkg::ColorW-1:0]    in_green_i,
  input  logic [wca_pkg::ColorW-1:0]    in_blue_i,
  input  logic [wca_pkg::ColorW-1:0]    in_alpha_i,
  input  logic [wca_pkg::WeightW-1:0]   contrib_weight_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wca_pkg::ColorW-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  output logic [wca_pkg::IndexW-1:0]    out_index_o,
  output logic [wca_pkg::ColorW-1:0]    out_red_o,
  output logic [wca_pkg::ColorW-1:0]    out_green_o,
  output logic [wca_pkg::ColorW-1:0]    out_blue_o,
  output logic [wca_pkg::ColorW-1:0]    out_alpha_o,
  output logic                          used_default_o
);
  import wca_pkg::*;

  wca_cmd_t cmd;
  wca_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wca_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  wca_dp #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .entry_index_i    (entry_index_i),
    .in_red_i         (in_red_i),
    .in_green_i       (in_green_i),
    .in_blue_i        (in_blue_i),
    .in_alpha_i       (in_alpha_i),
    .contrib_weight_i (contrib_weight_i),
    .out_valid_o      (out_valid_o),
    .out_index_o      (out_index_o),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .out_alpha_o      (out_alpha_o),
    .used_default_o   (used_default_o)
  );

endmodule

[dv/tb_weighted_color_average_table_core.sv]
module tb_weighted_color_average_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wca_pkg::*;

  localparam int unsigned Entries      = 256;
  localparam int unsigned SettleCycles = 50;   // outlasts the longest op, a finalize
  localparam logic [1:0]  ReqUnused    = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgRed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGreen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlue  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAlpha = 2'd3;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef logic [ChanCount-1:0][ColorW-1:0] color_t;  // [0] red .. [3] alpha

  typedef struct packed {
    logic [1:0]         kind;
    logic [IndexW-1:0]  idx;
    color_t             color;
    logic [WeightW-1:0] wt;
  } mix_req_t;

  typedef struct packed {
    logic [IndexW-1:0] idx;
    color_t            color;
    logic              dflt;
  } avg_color_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [1:0]           req_type_i;
  logic [IndexW-1:0]    entry_index_i;
  logic [ColorW-1:0]    in_red_i;
  logic [ColorW-1:0]    in_green_i;
  logic [ColorW-1:0]    in_blue_i;
  logic [ColorW-1:0]    in_alpha_i;
  logic [WeightW-1:0]   contrib_weight_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [ColorW-1:0]    cfg_data_i;
  logic                 out_valid_o;
  logic [IndexW-1:0]    out_index_o;
  logic [ColorW-1:0]    out_red_o;
  logic [ColorW-1:0]    out_green_o;
  logic [ColorW-1:0]    out_blue_o;
  logic [ColorW-1:0]    out_alpha_o;
  logic                 used_default_o;

  weighted_color_average_table_core #(
    .ENTRY_COUNT(Entries)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .in_red_i        (in_red_i),
    .in_green_i      (in_green_i),
    .in_blue_i       (in_blue_i),
    .in_alpha_i      (in_alpha_i),
    .contrib_weight_i(contrib_weight_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_index_o     (out_index_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o),
    .used_default_o  (used_default_o)
  );

  // shadow of the accumulator table and the default color
  logic [SumW-1:0]   chan_sum_m   [Entries][ChanCount];
  logic [TotalW-1:0] wt_total_m   [Entries];
  logic [ColorW-1:0] dflt_color_m [ChanCount];

  avg_color_t avg_color_q [$];

  int unsigned idle_pct;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_default;
  int unsigned n_clamp;
  int unsigned n_fail;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic table_apply(input mix_req_t rq);
    logic [SumW-1:0]   prod;
    logic [SumW:0]     acc;
    logic [TotalW:0]   tacc;
    logic [SumW-1:0]   quo;
    avg_color_t        res;
    if (rq.idx >= Entries) return;
    case (rq.kind)
      ReqSet: begin
        for (int c = 0; c < ChanCount; c++) begin
          chan_sum_m[rq.idx][c] = SumW'(rq.color[c]) * SumW'(rq.wt);
        end
        wt_total_m[rq.idx] = TotalW'(rq.wt);
      end
      ReqMix: begin
        for (int c = 0; c < ChanCount; c++) begin
          prod = SumW'(rq.color[c]) * SumW'(rq.wt);
          acc  = {1'b0, chan_sum_m[rq.idx][c]} + {1'b0, prod};
          chan_sum_m[rq.idx][c] = acc[SumW] ? SumMax : acc[SumW-1:0];
        end
        tacc = {1'b0, wt_total_m[rq.idx]} + (TotalW+1)'(rq.wt);
        wt_total_m[rq.idx] = tacc[TotalW] ? TotalMax : tacc[TotalW-1:0];
      end
      ReqFinal: begin
        res.idx = rq.idx;
        if (wt_total_m[rq.idx] == '0) begin
          for (int c = 0; c < ChanCount; c++) res.color[c] = dflt_color_m[c];
          res.dflt = 1'b1;
        end else begin
          for (int c = 0; c < ChanCount; c++) begin
            quo = chan_sum_m[rq.idx][c] / SumW'(wt_total_m[rq.idx]);
            if (quo > 255) n_clamp++;
            res.color[c] = (quo > 255) ? 8'hFF : quo[ColorW-1:0];
          end
          res.dflt = 1'b0;
        end
        avg_color_q.push_back(res);
      end
      default: ;  // unused code, dropped
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_fail++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    avg_color_t want;
    if (rst_ni && out_valid_o) begin
      if (avg_color_q.size() == 0) begin
        n_fail++;
        $error("result word for entry %0d with nothing pending", out_index_o);
      end else begin
        want = avg_color_q.pop_front();
        n_checked++;
        if (want.dflt) n_default++;
        check_field("out_index",    want.idx,      out_index_o);
        check_field("out_red",      want.color[0], out_red_o);
        check_field("out_green",    want.color[1], out_green_o);
        check_field("out_blue",     want.color[2], out_blue_o);
        check_field("out_alpha",    want.color[3], out_alpha_o);
        check_field("used_default", want.dflt,     used_default_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic mix_req_t mk_req(logic [1:0] kind, logic [IndexW-1:0] idx,
                                      color_t color, logic [WeightW-1:0] wt);
    mix_req_t rq;
    rq.kind  = kind;
    rq.idx   = idx;
    rq.color = color;
    rq.wt    = wt;
    return rq;
  endfunction

  task automatic issue_req(input mix_req_t rq);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      // mostly short gaps, now and then one that spans a whole finalize
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    req_type_i       <= rq.kind;
    entry_index_i    <= rq.idx;
    in_red_i         <= rq.color[0];
    in_green_i       <= rq.color[1];
    in_blue_i        <= rq.color[2];
    in_alpha_i       <= rq.color[3];
    contrib_weight_i <= rq.wt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    n_sent++;
    table_apply(rq);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ColorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dflt_color_m[idx] = data;
  endtask

  task automatic set_defaults(input color_t color);
    cfg_write(CfgRed,   color[0]);
    cfg_write(CfgGreen, color[1]);
    cfg_write(CfgBlue,  color[2]);
    cfg_write(CfgAlpha, color[3]);
    cfg_valid_i <= 1'b0;
  endtask

  // drop start, drain pending results, then let dropped / result-less ops finish
  task automatic settle();
    start_i <= 1'b0;
    while (avg_color_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  function automatic logic [ColorW-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ColorW'($urandom_range(255));
    endcase
  endfunction

  function automatic color_t rand_color();
    color_t c;
    for (int i = 0; i < ChanCount; i++) c[i] = rand_chan();
    return c;
  endfunction

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return WeightW'($urandom_range(65535));
      default: return WeightW'($urandom_range(1, 16'h2000));
    endcase
  endfunction

  // a few hot entries so sequences pile up, plus the full index range
  function automatic logic [IndexW-1:0] pick_index();
    return ($urandom_range(3) == 0) ? IndexW'($urandom_range(255))
                                    : IndexW'($urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_after_reset();
    issue_req(mk_req(ReqFinal, 8'd0,   '0, '0));
    issue_req(mk_req(ReqFinal, 8'd255, '1, '1));
    settle();
  endtask

  task automatic test_defaults();
    set_defaults('1);
    issue_req(mk_req(ReqFinal, 8'd7, '0, 16'h1234));
    settle();
    set_defaults({8'hF0, 8'h0F, 8'h5A, 8'hA5});
    issue_req(mk_req(ReqFinal, 8'd8, '1, '0));
    settle();
  endtask

  task automatic test_set_mix();
    issue_req(mk_req(ReqSet,   8'd255, '1, '1));
    issue_req(mk_req(ReqFinal, 8'd255, '0, '0));
    issue_req(mk_req(ReqSet,   8'd1, {8'd40, 8'd30, 8'd20, 8'd10}, 16'h1000));
    issue_req(mk_req(ReqMix,   8'd1, {8'd1, 8'd255, 8'd0, 8'd250}, 16'h3000));
    issue_req(mk_req(ReqFinal, 8'd1, '0, '0));
    // zero-weight set wipes the entry
    issue_req(mk_req(ReqSet,   8'd1, '1, '0));
    issue_req(mk_req(ReqFinal, 8'd1, '0, '0));
    issue_req(mk_req(ReqMix,   8'd1, '1, '0));
    issue_req(mk_req(ReqFinal, 8'd1, '0, '0));
    // smallest nonzero weight with a black color: not the default
    issue_req(mk_req(ReqMix,   8'd1, '0, 16'h0001));
    issue_req(mk_req(ReqFinal, 8'd1, '0, '0));
    // unused code leaves the entry alone
    issue_req(mk_req(ReqSet,    8'd2, {8'd4, 8'd3, 8'd2, 8'd1}, 16'h8000));
    issue_req(mk_req(ReqUnused, 8'd2, '1, '1));
    issue_req(mk_req(ReqFinal,  8'd2, '0, '0));
    issue_req(mk_req(ReqMix,    8'd3, {8'd77, 8'd128, 8'd0, 8'd255}, '1));
    issue_req(mk_req(ReqFinal,  8'd3, '0, '0));
    settle();
  endtask

  // drive one entry past both the total and the sum ceilings
  task automatic test_saturation();
    color_t c;
    c = {8'd0, 8'd1, 8'd128, 8'd255};
    issue_req(mk_req(ReqSet, 8'd200, c, '1));
    repeat (255) issue_req(mk_req(ReqMix, 8'd200, c, '1));
    issue_req(mk_req(ReqFinal, 8'd200, '0, '0));
    repeat (4) issue_req(mk_req(ReqMix, 8'd200, c, '1));
    issue_req(mk_req(ReqFinal, 8'd200, '0, '0));
    settle();
  endtask

  task automatic rand_sequence();
    logic [IndexW-1:0] idx;
    idx = pick_index();
    if ($urandom_range(3) != 0) issue_req(mk_req(ReqSet, idx, rand_color(), rand_weight()));
    repeat ($urandom_range(4)) issue_req(mk_req(ReqMix, idx, rand_color(), rand_weight()));
    issue_req(mk_req(ReqFinal, idx, rand_color(), rand_weight()));
  endtask

  task automatic test_random(input int unsigned idle, input int unsigned count);
    int unsigned target;
    idle_pct = idle;
    target   = n_sent + count;
    while (n_sent < target) begin
      if ($urandom_range(99) < 80) begin
        rand_sequence();
      end else begin
        issue_req(mk_req(2'($urandom_range(3)), pick_index(), rand_color(),
                         WeightW'($urandom_range(65535))));
      end
    end
    settle();
    idle_pct = 0;
  endtask

  initial begin
    for (int e = 0; e < Entries; e++) begin
      wt_total_m[e] = '0;
      for (int c = 0; c < ChanCount; c++) chan_sum_m[e][c] = '0;
    end
    for (int c = 0; c < ChanCount; c++) dflt_color_m[c] = '0;
    idle_pct  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_default = 0;
    n_clamp   = 0;
    n_fail    = 0;

    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    req_type_i       <= ReqSet;
    entry_index_i    <= '0;
    in_red_i         <= '0;
    in_green_i       <= '0;
    in_blue_i        <= '0;
    in_alpha_i       <= '0;
    contrib_weight_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CfgRed;
    cfg_data_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_defaults();
    test_set_mix();
    test_saturation();
    set_defaults(color_t'($urandom));
    test_random(26, 123);
    set_defaults('0);
    test_random(54, 123);
    set_defaults(color_t'($urandom));
    test_random(0, 122);

    $display("requests sent %0d, finalize words checked %0d", n_sent, n_checked);
    $display("default-color words %0d, clamped channels %0d, mismatches %0d",
             n_default, n_clamp, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
